// ===== hw/rtl/bis_pkg.sv =====
// Shared types and constants for the block importance scorer.
package bis_pkg;

    localparam int BLOCK_MAX_DEFAULT = 4096;
    localparam int SUM_W   = 44;
    localparam int CNT_W   = 17;
    localparam int SCORE_W = 30;
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] REG_METRIC_MODE = 2'd1;
    localparam logic [1:0] REG_USE_ACT = 2'd2;

    typedef struct packed {
        logic signed [15:0] weight_value;
        logic signed [15:0] companion_value;
        logic               last_of_tensor;
    } in_item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] block_score;
        logic [31:0]        block_number;
        logic               last_block;
    } out_item_t;

    // Closed block handed from front to back.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic [16:0]      first_mag;
        logic             fisher;
        logic [31:0]      number;
        logic             last;
    } blk_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_SQRT, ST_MUL, ST_DONE
    } back_state_t;

    function automatic logic [16:0] mag16(input logic [15:0] v);
        logic [16:0] r;
        r = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
        return r;
    endfunction

endpackage

// ===== hw/rtl/bis_front.sv =====
// Front end: accumulates terms per block and emits closed blocks.
module bis_front #(
    parameter int BLOCK_MAX = bis_pkg::BLOCK_MAX_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  bis_pkg::in_item_t in_item,
    input  logic [12:0]       size_limit,
    input  logic              metric_mode,
    input  logic              use_activations,
    output logic              blk_valid,
    input  logic              blk_ready,
    output bis_pkg::blk_t     blk
);
    import bis_pkg::*;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [16:0]      fmag_reg, fmag_next;
    logic [31:0]      num_reg, num_next;
    logic             blk_valid_reg;
    blk_t             blk_reg;
    logic [16:0]      wm, cm;
    logic [33:0]      term;
    logic [CNT_W-1:0] eff_size;
    logic [SUM_W-1:0] new_sum;
    logic [CNT_W-1:0] new_cnt;
    logic             close;
    logic             take;

    assign blk_valid = blk_valid_reg;
    assign blk = blk_reg;
    assign full = blk_valid_reg && !blk_ready;
    assign take = push && !full;
    assign wm = mag16(in_item.weight_value);
    assign cm = mag16(in_item.companion_value);

    always_comb
    begin
        if (size_limit == 13'd0)
            eff_size = CNT_W'(1);
        else if (CNT_W'(size_limit) > CNT_W'(BLOCK_MAX))
            eff_size = CNT_W'(BLOCK_MAX);
        else
            eff_size = CNT_W'(size_limit);
        if (metric_mode)
            term = cm * cm;
        else if (use_activations)
            term = wm * cm;
        else
            term = {5'd0, wm, 12'd0};
        new_sum = sum_reg + SUM_W'(term);
        new_cnt = cnt_reg + CNT_W'(1);
        close = (new_cnt >= eff_size) || in_item.last_of_tensor;
    end

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        fmag_next = fmag_reg;
        num_next = num_reg;
        if (take)
        begin
            if (close)
            begin
                sum_next = '0;
                cnt_next = '0;
                fmag_next = '0;
                num_next = in_item.last_of_tensor ? 32'd0 : num_reg + 32'd1;
            end
            else
            begin
                sum_next = new_sum;
                cnt_next = new_cnt;
                if (cnt_reg == '0)
                    fmag_next = wm;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            fmag_reg <= '0;
            num_reg <= '0;
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            fmag_reg <= fmag_next;
            num_reg <= num_next;
            if (take && close)
                blk_valid_reg <= 1'b1;
            else if (blk_ready)
                blk_valid_reg <= 1'b0;
        end
    end

    // Hold the closed block until the back end takes it.
    always_ff @(posedge clk)
    begin
        if (take && close)
        begin
            blk_reg.sum <= new_sum;
            blk_reg.count <= new_cnt;
            blk_reg.first_mag <= (cnt_reg == '0) ? wm : fmag_reg;
            blk_reg.fisher <= metric_mode;
            blk_reg.number <= num_reg;
            blk_reg.last <= in_item.last_of_tensor;
        end
    end

endmodule

// ===== hw/rtl/bis_back.sv =====
// Back end: divide, then (Fisher blocks only) square root and scale, and saturate, one block at a time.
module bis_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               blk_valid,
    output logic               blk_ready,
    input  bis_pkg::blk_t      blk,
    output logic               empty,
    input  logic               pop,
    output bis_pkg::out_item_t out_item
);
    import bis_pkg::*;

    back_state_t state_reg, state_next;
    logic [SUM_W-1:0] rem_reg, quo_reg;
    logic [CNT_W-1:0] den_reg;
    logic [5:0]       step_reg;
    logic [16:0]      fmag_reg;
    logic             fisher_reg, last_reg;
    logic [31:0]      num_reg;
    logic [55:0]      rad_reg;
    logic [28:0]      root_reg;
    logic [28:0]      sq_rem_reg;
    out_item_t        out_item_reg;
    logic [SUM_W:0]   rem_sh;
    logic             q_bit;
    logic [SUM_W-1:0] quo_fin;
    logic [30:0]      sq_trial;
    logic [30:0]      sq_cur;
    logic [45:0]      prod;
    logic [SCORE_W-1:0] score;
    logic             out_valid_reg;

    assign empty = !out_valid_reg;
    assign out_item = out_item_reg;
    assign blk_ready = (state_reg == ST_IDLE);
    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign q_bit = (rem_sh >= (SUM_W+1)'(den_reg));
    assign quo_fin = {quo_reg[SUM_W-2:0], q_bit};
    assign sq_cur = {sq_rem_reg, rad_reg[55:54]};
    assign sq_trial = {root_reg, 2'b01};
    assign prod = root_reg * fmag_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (blk_valid) state_next = ST_DIV;
            ST_DIV:  if (step_reg == 6'd0)
                         state_next = fisher_reg ? ST_SQRT : ST_DONE;
            ST_SQRT: if (step_reg == 6'd0) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE: if (!out_valid_reg || pop) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        score = (quo_reg > SUM_W'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(quo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && state_next == ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                rem_reg <= '0;
                quo_reg <= blk.sum;
                den_reg <= blk.count;
                fmag_reg <= blk.first_mag;
                fisher_reg <= blk.fisher;
                num_reg <= blk.number;
                last_reg <= blk.last;
                step_reg <= 6'(SUM_W - 1);
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (q_bit)
                    rem_reg <= SUM_W'(rem_sh - (SUM_W+1)'(den_reg));
                else
                    rem_reg <= SUM_W'(rem_sh);
                quo_reg <= quo_fin;
                if (step_reg == 6'd0)
                begin
                    // clamp mean to 2^30 and shift into radicand
                    if (quo_fin > (SUM_W'(1) << 30))
                        rad_reg <= {2'b01, 54'd0};
                    else
                        rad_reg <= {1'b0, quo_fin[30:0], 24'd0};
                    root_reg <= '0;
                    sq_rem_reg <= '0;
                    step_reg <= 6'd27;
                end
                else
                    step_reg <= step_reg - 6'd1;
            end
            ST_SQRT:
            begin
                // two radicand bits per cycle
                if (sq_cur >= sq_trial)
                begin
                    sq_rem_reg <= 29'(sq_cur - sq_trial);
                    root_reg <= {root_reg[27:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= 29'(sq_cur);
                    root_reg <= {root_reg[27:0], 1'b0};
                end
                rad_reg <= {rad_reg[53:0], 2'b00};
                if (step_reg != 6'd0)
                    step_reg <= step_reg - 6'd1;
            end
            ST_MUL:
            begin
                quo_reg <= SUM_W'(prod >> 12);
            end
            ST_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_item_reg.block_score <= score;
                    out_item_reg.block_number <= num_reg;
                    out_item_reg.last_block <= last_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/block_importance_scorer_top.sv =====
// Block importance scorer: accumulates weight saliency per block, divides at block end.
// Throughput: one input per cycle inside a block; a closed block waits in a one-entry queue
// while the back end works, then input stalls.
// Reset clears all accumulators and the block counter and restores the config defaults.
module block_importance_scorer_top #(
    parameter int BLOCK_MAX = bis_pkg::BLOCK_MAX_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bis_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output bis_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data
);
    import bis_pkg::*;

    logic [12:0] size_limit_reg;
    logic        metric_mode_reg;
    logic        use_act_reg;
    logic        blk_valid, blk_ready;
    blk_t        blk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_limit_reg <= 13'd256;
            metric_mode_reg <= 1'b0;
            use_act_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE:  size_limit_reg <= cfg_data;
                REG_METRIC_MODE: metric_mode_reg <= cfg_data[0];
                REG_USE_ACT:     use_act_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    bis_front #(.BLOCK_MAX(BLOCK_MAX)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .size_limit(size_limit_reg), .metric_mode(metric_mode_reg),
        .use_activations(use_act_reg),
        .blk_valid(blk_valid), .blk_ready(blk_ready), .blk(blk)
    );

    bis_back u_back (
        .clk(clk), .rst_n(rst_n), .blk_valid(blk_valid), .blk_ready(blk_ready),
        .blk(blk), .empty(empty), .pop(pop), .out_item(out_item)
    );

endmodule
